/* design/sensor_setup_sequencer_defines.svh */
// assertion macros shared by the checker
`ifndef SENSOR_SETUP_SEQUENCER_DEFINES_SVH
`define SENSOR_SETUP_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define SSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sss_pkg.sv */
// shared types and constants of the sensor setup sequencer
`timescale 1ns / 1ps
package sss_pkg;

  localparam int TIME_W  = 32;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;
  localparam int OP_W    = 3;
  localparam int CMD_W   = 4;
  localparam int PHASE_W = 3;
  localparam int RETRY_W = 4;
  localparam int STEP_W  = 5;

  localparam int INIT_COMMANDS = 10;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // message classes
  localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
  localparam logic [OP_W-1:0] OP_PROMPT     = 3'd1;
  localparam logic [OP_W-1:0] OP_SETUP_LINE = 3'd2;
  localparam logic [OP_W-1:0] OP_REPORT_OK  = 3'd3;
  localparam logic [OP_W-1:0] OP_REPORT_BAD = 3'd4;
  localparam logic [OP_W-1:0] OP_UNITS_OK   = 3'd5;
  localparam logic [OP_W-1:0] OP_UNITS_BAD  = 3'd6;
  localparam logic [OP_W-1:0] OP_OTHER      = 3'd7;

  // command ids
  localparam logic [CMD_W-1:0] CMD_EXIT      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INIT_BASE = 4'd2;
  localparam logic [CMD_W-1:0] CMD_REPORT    = 4'd12;
  localparam logic [CMD_W-1:0] CMD_UNITS     = 4'd13;

  // phase codes
  localparam logic [PHASE_W-1:0] PHASE_POWER_UP = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_EXIT     = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_SETUP    = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_INIT     = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_REPORT   = 3'd4;
  localparam logic [PHASE_W-1:0] PHASE_UNITS    = 3'd5;
  localparam logic [PHASE_W-1:0] PHASE_LEAVE    = 3'd6;
  localparam logic [PHASE_W-1:0] PHASE_WATCH    = 3'd7;

  // register indexes
  localparam logic [1:0] REG_POWER_UP_WAIT  = 2'd0;
  localparam logic [1:0] REG_REPLY_WAIT     = 2'd1;
  localparam logic [1:0] REG_WATCHDOG_WAIT  = 2'd2;
  localparam logic [1:0] REG_VERIFY_RETRIES = 2'd3;

  localparam logic [TIME_W-1:0]  POWER_UP_WAIT_RST  = 32'd950000000;
  localparam logic [TIME_W-1:0]  REPLY_WAIT_RST     = 32'd10000000;
  localparam logic [TIME_W-1:0]  WATCHDOG_WAIT_RST  = 32'd500000000;
  localparam logic [RETRY_W-1:0] VERIFY_RETRIES_RST = 4'd3;

  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic              prompt;
    logic              setup_line;
    logic              report_ok;
    logic              report_bad;
    logic              units_ok;
    logic              units_bad;
    logic              traffic;
  } msg_t;

  typedef struct packed {
    logic [TIME_W-1:0]  power_up_wait;
    logic [TIME_W-1:0]  reply_wait;
    logic [TIME_W-1:0]  watchdog_wait;
    logic [RETRY_W-1:0] verify_retries;
  } cfg_t;

  typedef struct packed {
    logic               send_valid;
    logic [CMD_W-1:0]   command;
    logic               restart_link;
    logic [PHASE_W-1:0] phase;
  } result_t;

endpackage

/* design/sss_front.sv */
// front part: classifies the message of each poll
`timescale 1ns / 1ps
module sss_front import sss_pkg::*; (
  input  logic [TIME_W-1:0] now,
  input  logic [OP_W-1:0]   opcode,
  output msg_t              msg
);

  always_comb begin
    msg            = '0;
    msg.now        = now;
    msg.traffic    = (opcode != OP_NONE);
    case (opcode)
      OP_PROMPT:     msg.prompt     = 1'b1;
      OP_SETUP_LINE: msg.setup_line = 1'b1;
      OP_REPORT_OK:  msg.report_ok  = 1'b1;
      OP_REPORT_BAD: msg.report_bad = 1'b1;
      OP_UNITS_OK:   msg.units_ok   = 1'b1;
      OP_UNITS_BAD:  msg.units_bad  = 1'b1;
      default: ;
    endcase
  end

endmodule

/* design/sss_queue.sv */
// short queue between front and back parts
`timescale 1ns / 1ps
module sss_queue import sss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  msg_t push_msg,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output msg_t pop_msg
);

  msg_t                entry [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_msg   = entry[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_msg;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/sss_back.sv */
// back part: phase sequencer and result register
`timescale 1ns / 1ps
module sss_back import sss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    msg_valid,
  input  msg_t    msg,
  output logic    msg_pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  typedef enum logic [PHASE_W-1:0] {
    PH_POWER  = PHASE_POWER_UP,
    PH_EXIT   = PHASE_EXIT,
    PH_SETUP  = PHASE_SETUP,
    PH_INIT   = PHASE_INIT,
    PH_REPORT = PHASE_REPORT,
    PH_UNITS  = PHASE_UNITS,
    PH_LEAVE  = PHASE_LEAVE,
    PH_WATCH  = PHASE_WATCH
  } phase_t;

  phase_t              phase;
  logic                entering;
  logic [TIME_W-1:0]   deadline;
  logic [STEP_W-1:0]   step_count;
  logic                in_setup;
  logic                saw_prompt;
  logic                saw_reply;
  logic                report_good;
  logic                units_good;
  logic                traffic_seen;

  phase_t              phase_next;
  logic [TIME_W-1:0]   deadline_next;
  logic [STEP_W-1:0]   step_count_next;
  logic                in_setup_next;
  logic                saw_prompt_next;
  logic                saw_reply_next;
  logic                report_good_next;
  logic                units_good_next;
  logic                traffic_seen_next;
  result_t             result_next;

  logic [TIME_W-1:0]   since;
  logic                due;
  logic                go;
  phase_t              target;
  logic                load;
  logic [TIME_W-1:0]   wait_cycles;
  logic                out_free;
  logic                retries_out;

  assign since       = msg.now - deadline;
  assign due         = !since[TIME_W-1];
  assign out_free    = !result_valid || !result_stall;
  assign msg_pop     = msg_valid && out_free;
  assign retries_out = (step_count > STEP_W'(cfg.verify_retries));

  always_comb begin
    phase_next        = phase;
    step_count_next   = step_count;
    in_setup_next     = in_setup;
    saw_prompt_next   = saw_prompt;
    saw_reply_next    = saw_reply;
    report_good_next  = report_good;
    units_good_next   = units_good;
    traffic_seen_next = traffic_seen;
    result_next       = '0;
    go                = 1'b0;
    target            = PH_POWER;
    load              = 1'b0;
    wait_cycles       = cfg.reply_wait;

    case (phase)
      PH_POWER: begin
        if (entering) begin
          load                     = 1'b1;
          wait_cycles              = cfg.power_up_wait;
          traffic_seen_next        = 1'b0;
          result_next.restart_link = 1'b1;
        end else if (due) begin
          go     = 1'b1;
          target = PH_EXIT;
        end
      end
      PH_EXIT: begin
        if (due) begin
          go     = 1'b1;
          target = PH_SETUP;
        end
      end
      PH_SETUP: begin
        if (in_setup && saw_prompt) begin
          go     = 1'b1;
          target = PH_INIT;
        end else if (due) begin
          go     = 1'b1;
          target = PH_POWER;
        end
      end
      PH_INIT: begin
        if (saw_reply || saw_prompt || due) begin
          if (step_count < STEP_W'(INIT_COMMANDS)) begin
            saw_reply_next         = 1'b0;
            saw_prompt_next        = 1'b0;
            load                   = 1'b1;
            result_next.send_valid = 1'b1;
            result_next.command    = CMD_INIT_BASE + step_count[CMD_W-1:0];
            step_count_next        = step_count + 1'b1;
          end else begin
            go     = 1'b1;
            target = PH_REPORT;
          end
        end
      end
      PH_REPORT, PH_UNITS: begin
        if ((phase == PH_REPORT) ? report_good : units_good) begin
          go     = 1'b1;
          target = (phase == PH_REPORT) ? PH_UNITS : PH_LEAVE;
        end else if (retries_out) begin
          go     = 1'b1;
          target = PH_POWER;
        end else if (due) begin
          load                   = 1'b1;
          saw_reply_next         = 1'b0;
          result_next.send_valid = 1'b1;
          result_next.command    = (phase == PH_REPORT) ? CMD_REPORT : CMD_UNITS;
          if (step_count != '1) begin
            step_count_next = step_count + 1'b1;
          end
        end else if (saw_reply) begin
          go     = 1'b1;
          target = PH_POWER;
        end
      end
      PH_LEAVE: begin
        go     = 1'b1;
        target = PH_LEAVE;
      end
      PH_WATCH: begin
        if (traffic_seen) begin
          load              = 1'b1;
          wait_cycles       = cfg.watchdog_wait;
          traffic_seen_next = 1'b0;
        end else if (due) begin
          go     = 1'b1;
          target = PH_POWER;
        end
      end
      default: ;
    endcase

    // entry action of the phase just reached
    if (go) begin
      phase_next = target;
      case (target)
        PH_POWER: begin
          load                     = 1'b1;
          wait_cycles              = cfg.power_up_wait;
          traffic_seen_next        = 1'b0;
          result_next.restart_link = 1'b1;
        end
        PH_EXIT: begin
          load                   = 1'b1;
          result_next.send_valid = 1'b1;
          result_next.command    = CMD_EXIT;
        end
        PH_SETUP: begin
          load                   = 1'b1;
          in_setup_next          = 1'b0;
          saw_prompt_next        = 1'b0;
          result_next.send_valid = 1'b1;
          result_next.command    = CMD_QUERY;
        end
        PH_INIT: begin
          load                   = 1'b1;
          saw_reply_next         = 1'b0;
          saw_prompt_next        = 1'b0;
          step_count_next        = STEP_W'(1);
          result_next.send_valid = 1'b1;
          result_next.command    = CMD_INIT_BASE;
        end
        PH_REPORT: begin
          load                   = 1'b1;
          saw_reply_next         = 1'b0;
          report_good_next       = 1'b0;
          step_count_next        = STEP_W'(1);
          result_next.send_valid = 1'b1;
          result_next.command    = CMD_REPORT;
        end
        PH_UNITS: begin
          load                   = 1'b1;
          saw_reply_next         = 1'b0;
          units_good_next        = 1'b0;
          step_count_next        = STEP_W'(1);
          result_next.send_valid = 1'b1;
          result_next.command    = CMD_UNITS;
        end
        default: begin
          // leave setup, then arm the watchdog
          phase_next             = PH_WATCH;
          load                   = 1'b1;
          wait_cycles            = cfg.watchdog_wait;
          in_setup_next          = 1'b0;
          traffic_seen_next      = 1'b0;
          result_next.send_valid = 1'b1;
          result_next.command    = CMD_EXIT;
        end
      endcase
    end

    deadline_next = load ? (msg.now + wait_cycles) : deadline;

    // message of this poll
    if (msg.prompt) begin
      saw_prompt_next = 1'b1;
    end
    if (msg.setup_line) begin
      in_setup_next  = 1'b1;
      saw_reply_next = 1'b1;
    end
    if (msg.report_ok || msg.report_bad) begin
      report_good_next = msg.report_ok;
      saw_reply_next   = 1'b1;
    end
    if (msg.units_ok || msg.units_bad) begin
      units_good_next = msg.units_ok;
      saw_reply_next  = 1'b1;
    end
    if (msg.traffic) begin
      traffic_seen_next = 1'b1;
    end

    result_next.phase = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_POWER;
      entering     <= 1'b1;
      deadline     <= '0;
      step_count   <= '0;
      in_setup     <= 1'b0;
      saw_prompt   <= 1'b0;
      saw_reply    <= 1'b0;
      report_good  <= 1'b0;
      units_good   <= 1'b0;
      traffic_seen <= 1'b0;
      result_valid <= 1'b0;
    end else if (msg_pop) begin
      phase        <= phase_next;
      entering     <= 1'b0;
      deadline     <= deadline_next;
      step_count   <= step_count_next;
      in_setup     <= in_setup_next;
      saw_prompt   <= saw_prompt_next;
      saw_reply    <= saw_reply_next;
      report_good  <= report_good_next;
      units_good   <= units_good_next;
      traffic_seen <= traffic_seen_next;
      result_valid <= 1'b1;
      result       <= result_next;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

/* design/sensor_setup_sequencer.sv */
// sensor setup sequencer: top level with register port
//
// one poll per transfer on the poll channel (now, opcode); one result per
// poll on the result channel (send_valid, command, restart_link, phase).
// a poll transfer goes into a two-entry queue; the sequencer takes it from
// there in order and registers its result in the output register.
// throughput is one poll per cycle while result_stall is low; each poll
// makes one phase update (one deadline compare, one deadline add).
// while result_stall is high the result holds; up to two more polls are
// taken into the queue before poll_stall rises.
// reset empties the queue, clears result_valid and returns the
// registers to their defaults; the first poll after reset starts the
// power-up wait and shows restart_link.
// registers sit at byte addresses 0, 4, 8, 12; the user must write them
// only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
module sensor_setup_sequencer import sss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               poll_valid,
  output logic               poll_stall,
  input  logic [TIME_W-1:0]  now,
  input  logic [OP_W-1:0]    opcode,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               send_valid,
  output logic [CMD_W-1:0]   command,
  output logic               restart_link,
  output logic [PHASE_W-1:0] phase,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t       cfg;
  msg_t       front_msg;
  msg_t       back_msg;
  logic       queue_full;
  logic       back_valid;
  logic       back_pop;
  result_t    result;
  logic       reg_write;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_up_wait  <= POWER_UP_WAIT_RST;
      cfg.reply_wait     <= REPLY_WAIT_RST;
      cfg.watchdog_wait  <= WATCHDOG_WAIT_RST;
      cfg.verify_retries <= VERIFY_RETRIES_RST;
    end else if (reg_write) begin
      case (reg_index)
        REG_POWER_UP_WAIT:  cfg.power_up_wait  <= pwdata;
        REG_REPLY_WAIT:     cfg.reply_wait     <= pwdata;
        REG_WATCHDOG_WAIT:  cfg.watchdog_wait  <= pwdata;
        REG_VERIFY_RETRIES: cfg.verify_retries <= pwdata[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_POWER_UP_WAIT:  prdata = cfg.power_up_wait;
      REG_REPLY_WAIT:     prdata = cfg.reply_wait;
      REG_WATCHDOG_WAIT:  prdata = cfg.watchdog_wait;
      REG_VERIFY_RETRIES: prdata = DATA_W'(cfg.verify_retries);
      default:            prdata = '0;
    endcase
  end

  sss_front u_front (
    .now    (now),
    .opcode (opcode),
    .msg    (front_msg)
  );

  assign poll_stall = queue_full;

  sss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (poll_valid),
    .push_msg  (front_msg),
    .full      (queue_full),
    .pop       (back_pop),
    .pop_valid (back_valid),
    .pop_msg   (back_msg)
  );

  sss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .msg_valid    (back_valid),
    .msg          (back_msg),
    .msg_pop      (back_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign send_valid   = result.send_valid;
  assign command      = result.command;
  assign restart_link = result.restart_link;
  assign phase        = result.phase;

endmodule

/* design/sss_checker.sv */
// port checker for the sensor setup sequencer, with its bind
`timescale 1ns / 1ps
`include "sensor_setup_sequencer_defines.svh"
module sss_checker import sss_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input logic               send_valid,
  input logic [CMD_W-1:0]   command,
  input logic               restart_link,
  input logic [PHASE_W-1:0] phase
);

  `SSS_ASSERT_NEXT(a_stalled_result_holds, result_valid && result_stall, result_valid && $stable(command) && $stable(phase) && $stable(send_valid), "stalled result changed")
  `SSS_ASSERT_NOW(a_idle_command_zero, result_valid && !send_valid, command == CMD_EXIT, "command set without send")
  `SSS_ASSERT_NOW(a_restart_in_power_up, result_valid && restart_link, phase == PHASE_POWER_UP && !send_valid, "restart outside power-up wait")
  `SSS_ASSERT_NOW(a_leave_is_transient, result_valid, phase != PHASE_LEAVE, "leave phase reported")
  `SSS_ASSERT_NOW(a_watch_sends_exit, result_valid && send_valid && phase == PHASE_WATCH, command == CMD_EXIT, "wrong command on entering watchdog")

endmodule

bind sensor_setup_sequencer sss_checker u_sss_checker (.*);

/* bench/sss_poll_checker.sv */
// poll result checker for the sensor setup sequencer: predicts, queues and compares results
`timescale 1ns / 1ps
module sss_poll_checker import sss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               poll_valid,
  input  logic               poll_stall,
  input  logic [TIME_W-1:0]  now,
  input  logic [OP_W-1:0]    opcode,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic               send_valid,
  input  logic [CMD_W-1:0]   command,
  input  logic               restart_link,
  input  logic [PHASE_W-1:0] phase,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 open_count,
  output int                 checked_count,
  output int                 command_count,
  output int                 restart_count,
  output logic [PHASE_W-1:0] phase_hint
);

  logic [TIME_W-1:0]  wait_power;
  logic [TIME_W-1:0]  wait_reply;
  logic [TIME_W-1:0]  wait_watch;
  logic [RETRY_W-1:0] retries_allowed;

  logic [PHASE_W-1:0] seq_phase;
  logic               seq_entering;
  logic [TIME_W-1:0]  seq_deadline;
  logic [STEP_W-1:0]  seq_steps;
  logic               in_setup_f;
  logic               prompt_f;
  logic               reply_f;
  logic               report_ok_f;
  logic               units_ok_f;
  logic               traffic_f;

  logic               cmd_sent;
  logic [CMD_W-1:0]   cmd_id;
  logic               link_restarted;

  result_t awaited_results[$];

  function automatic logic deadline_reached(input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] diff;
    diff = t - seq_deadline;
    return !diff[TIME_W-1];
  endfunction

  task automatic issue(input logic [CMD_W-1:0] id);
    cmd_sent = 1'b1;
    cmd_id = id;
  endtask

  task automatic query_format(input logic [TIME_W-1:0] t, input logic is_units,
                              input logic [CMD_W-1:0] id, input logic [PHASE_W-1:0] next_phase);
    logic good;
    good = is_units ? units_ok_f : report_ok_f;
    if (seq_entering) begin
      seq_steps = '0;
      reply_f = 1'b0;
      good = 1'b0;
    end
    if (good) begin
      seq_phase = next_phase;
    end else if (seq_steps > {1'b0, retries_allowed}) begin
      seq_phase = PHASE_POWER_UP;
    end else if (seq_entering || deadline_reached(t)) begin
      seq_deadline = t + wait_reply;
      reply_f = 1'b0;
      issue(id);
      if (seq_steps != {STEP_W{1'b1}}) begin
        seq_steps = seq_steps + 1'b1;
      end
    end else if (reply_f) begin
      seq_phase = PHASE_POWER_UP;
    end
    if (is_units) begin
      units_ok_f = good;
    end else begin
      report_ok_f = good;
    end
  endtask

  task automatic predict_poll_result(input logic [TIME_W-1:0] t, input logic [OP_W-1:0] op,
                                     output result_t res);
    logic [PHASE_W-1:0] prior;
    cmd_sent = 1'b0;
    cmd_id = CMD_EXIT;
    link_restarted = 1'b0;
    // follow phase changes within one poll until a phase stays put
    for (int pass = 0; pass < 8; pass++) begin
      prior = seq_phase;
      case (seq_phase)
        PHASE_POWER_UP: begin
          if (seq_entering) begin
            seq_deadline = t + wait_power;
            traffic_f = 1'b0;
            link_restarted = 1'b1;
          end else if (deadline_reached(t)) begin
            seq_phase = PHASE_EXIT;
          end
        end
        PHASE_EXIT: begin
          if (seq_entering) begin
            seq_deadline = t + wait_reply;
            issue(CMD_EXIT);
          end else if (deadline_reached(t)) begin
            seq_phase = PHASE_SETUP;
          end
        end
        PHASE_SETUP: begin
          if (seq_entering) begin
            seq_deadline = t + wait_reply;
            in_setup_f = 1'b0;
            prompt_f = 1'b0;
            issue(CMD_QUERY);
          end else if (in_setup_f && prompt_f) begin
            seq_phase = PHASE_INIT;
          end else if (deadline_reached(t)) begin
            seq_phase = PHASE_POWER_UP;
          end
        end
        PHASE_INIT: begin
          if (seq_entering) begin
            seq_steps = '0;
          end
          if (seq_entering || reply_f || prompt_f || deadline_reached(t)) begin
            if (seq_steps < INIT_COMMANDS) begin
              reply_f = 1'b0;
              prompt_f = 1'b0;
              seq_deadline = t + wait_reply;
              issue(CMD_INIT_BASE + seq_steps[CMD_W-1:0]);
              seq_steps = seq_steps + 1'b1;
            end else begin
              seq_phase = PHASE_REPORT;
            end
          end
        end
        PHASE_REPORT: query_format(t, 1'b0, CMD_REPORT, PHASE_UNITS);
        PHASE_UNITS: query_format(t, 1'b1, CMD_UNITS, PHASE_LEAVE);
        PHASE_LEAVE: begin
          issue(CMD_EXIT);
          in_setup_f = 1'b0;
          seq_phase = PHASE_WATCH;
        end
        default: begin
          if (seq_entering || traffic_f) begin
            seq_deadline = t + wait_watch;
            traffic_f = 1'b0;
          end else if (deadline_reached(t)) begin
            seq_phase = PHASE_POWER_UP;
          end
        end
      endcase
      seq_entering = (prior != seq_phase);
      if (!seq_entering) break;
    end
    // the message is taken in after the phase update, even on a link restart
    case (op)
      OP_PROMPT: prompt_f = 1'b1;
      OP_SETUP_LINE: begin
        in_setup_f = 1'b1;
        reply_f = 1'b1;
      end
      OP_REPORT_OK: begin
        report_ok_f = 1'b1;
        reply_f = 1'b1;
      end
      OP_REPORT_BAD: begin
        report_ok_f = 1'b0;
        reply_f = 1'b1;
      end
      OP_UNITS_OK: begin
        units_ok_f = 1'b1;
        reply_f = 1'b1;
      end
      OP_UNITS_BAD: begin
        units_ok_f = 1'b0;
        reply_f = 1'b1;
      end
      default: ;
    endcase
    if (op != OP_NONE) begin
      traffic_f = 1'b1;
    end
    res.send_valid = cmd_sent;
    res.command = cmd_sent ? cmd_id : CMD_EXIT;
    res.restart_link = link_restarted;
    res.phase = seq_phase;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    result_t fresh;
    if (rst) begin
      wait_power = POWER_UP_WAIT_RST;
      wait_reply = REPLY_WAIT_RST;
      wait_watch = WATCHDOG_WAIT_RST;
      retries_allowed = VERIFY_RETRIES_RST;
      seq_phase = PHASE_POWER_UP;
      seq_entering = 1'b1;
      seq_deadline = '0;
      seq_steps = '0;
      in_setup_f = 1'b0;
      prompt_f = 1'b0;
      reply_f = 1'b0;
      report_ok_f = 1'b0;
      units_ok_f = 1'b0;
      traffic_f = 1'b0;
      awaited_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        got = {send_valid, command, restart_link, phase};
        if (awaited_results.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result transfer: send=%0b cmd=%0d restart=%0b phase=%0d",
                     got.send_valid, got.command, got.restart_link, got.phase);
          end
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (got.send_valid !== want.send_valid || got.command !== want.command ||
              got.restart_link !== want.restart_link || got.phase !== want.phase) begin
            if (fail_count < 10) begin
              $display("result %0d mismatch: expected send=%0b cmd=%0d restart=%0b phase=%0d",
                       checked_count, want.send_valid, want.command, want.restart_link,
                       want.phase);
              $display("  actual send=%0b cmd=%0d restart=%0b phase=%0d",
                       got.send_valid, got.command, got.restart_link, got.phase);
            end
            fail_count <= fail_count + 1;
          end
          checked_count <= checked_count + 1;
          command_count <= command_count + got.send_valid;
          restart_count <= restart_count + got.restart_link;
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_POWER_UP_WAIT: wait_power = pwdata;
          REG_REPLY_WAIT: wait_reply = pwdata;
          REG_WATCHDOG_WAIT: wait_watch = pwdata;
          REG_VERIFY_RETRIES: retries_allowed = pwdata[RETRY_W-1:0];
          default: ;
        endcase
      end
      if (poll_valid && !poll_stall) begin
        predict_poll_result(now, opcode, fresh);
        awaited_results.push_back(fresh);
      end
    end
    open_count <= awaited_results.size();
    phase_hint <= seq_phase;
  end

endmodule

/* bench/tb_sensor_setup_sequencer.sv */
// testbench top for the sensor setup sequencer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_sensor_setup_sequencer import sss_pkg::*; ();

  localparam int RUN_LIMIT = 300000;
  localparam int REG_SETS = 8;
  localparam int POLLS_PER_SET = 100;

  logic               clk;
  logic               rst;
  logic               poll_valid;
  logic               poll_stall;
  logic [TIME_W-1:0]  now;
  logic [OP_W-1:0]    opcode;
  logic               result_valid;
  logic               result_stall;
  logic               send_valid;
  logic [CMD_W-1:0]   command;
  logic               restart_link;
  logic [PHASE_W-1:0] phase;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int                 fail_count;
  int                 open_count;
  int                 checked_count;
  int                 command_count;
  int                 restart_count;
  logic [PHASE_W-1:0] phase_hint;

  int                 cycle_count = 0;
  int                 poll_count = 0;
  int                 sender_idle_pct = 0;
  int                 stall_pct = 0;
  logic [TIME_W-1:0]  span_power;
  logic [TIME_W-1:0]  span_reply;
  logic [TIME_W-1:0]  span_watch;

  sensor_setup_sequencer uut (.*);

  sss_poll_checker monitor (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, open_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic load_registers(input logic [TIME_W-1:0] pw, input logic [TIME_W-1:0] rw,
                                input logic [TIME_W-1:0] ww, input logic [RETRY_W-1:0] nr);
    write_reg(REG_POWER_UP_WAIT, pw);
    write_reg(REG_REPLY_WAIT, rw);
    write_reg(REG_WATCHDOG_WAIT, ww);
    write_reg(REG_VERIFY_RETRIES, DATA_W'(nr));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    span_power = pw;
    span_reply = rw;
    span_watch = ww;
  endtask

  task automatic send_poll(input logic [TIME_W-1:0] t, input logic [OP_W-1:0] op);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      poll_valid <= 1'b0;
      @(posedge clk);
    end
    poll_valid <= 1'b1;
    now <= t;
    opcode <= op;
    @(posedge clk);
    while (poll_stall) @(posedge clk);
    poll_count++;
  endtask

  task automatic drain();
    poll_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] dt;
    logic [OP_W-1:0]   op;
    int                roll;
    rst <= 1'b1;
    poll_valid <= 1'b0;
    now <= '0;
    opcode <= OP_NONE;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // short waits so a full bring-up fits in a couple dozen polls across the counter wrap
    load_registers(32'd4, 32'd3, 32'd6, 4'd1);
    t = 32'hFFFF_FFF0;
    send_poll(t, OP_NONE);
    t += 2; send_poll(t, OP_OTHER);
    t += 3; send_poll(t, OP_NONE);
    t += 4; send_poll(t, OP_PROMPT);
    t += 1; send_poll(t, OP_SETUP_LINE);
    t += 1; send_poll(t, OP_PROMPT);
    t += 1; send_poll(t, OP_REPORT_BAD);
    t += 1; send_poll(t, OP_UNITS_OK);
    t += 1; send_poll(t, OP_UNITS_BAD);
    t += 1; send_poll(t, OP_SETUP_LINE);
    t += 1; send_poll(t, OP_REPORT_OK);
    t += 1; send_poll(t, OP_NONE);
    t += 1; send_poll(t, OP_NONE);
    t += 2; send_poll(t, OP_PROMPT);
    t += 1; send_poll(t, OP_PROMPT);
    t += 1; send_poll(t, OP_PROMPT);
    t += 1; send_poll(t, OP_REPORT_OK);
    t += 1; send_poll(t, OP_NONE);
    t += 3; send_poll(t, OP_UNITS_OK);
    t += 1; send_poll(t, OP_OTHER);
    t += 1; send_poll(t, OP_NONE);
    t += 6; send_poll(t, OP_PROMPT);
    t += 4; send_poll(t, OP_SETUP_LINE);

    for (int round = 0; round < REG_SETS; round++) begin
      drain();
      case (round)
        0: load_registers(POWER_UP_WAIT_RST, REPLY_WAIT_RST, WATCHDOG_WAIT_RST,
                          VERIFY_RETRIES_RST);
        1: load_registers(32'd20, 32'd6, 32'd40, 4'd3);
        2: load_registers('0, '0, '0, '0);
        3: load_registers('1, '1, '1, '1);
        4: load_registers($urandom_range(0, 50), $urandom_range(0, 20), $urandom_range(0, 80),
                          RETRY_W'($urandom_range(0, 15)));
        5: load_registers(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 4'd2);
        6: load_registers($urandom, $urandom, $urandom, RETRY_W'($urandom_range(0, 15)));
        default: load_registers($urandom_range(1, 10), $urandom_range(1, 8),
                                $urandom_range(1, 30), 4'd1);
      endcase
      case (round % 4)
        0: begin
          sender_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 59;
          stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct = 59;
        end
        default: begin
          sender_idle_pct = 11;
          stall_pct = 11;
        end
      endcase
      repeat (POLLS_PER_SET) begin
        case (phase_hint)
          PHASE_POWER_UP: span = span_power;
          PHASE_WATCH: span = span_watch;
          default: span = span_reply;
        endcase
        // mostly small steps, often a step onto the pending deadline, rarely a wild jump
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          dt = $urandom_range(0, 2);
        end else if (roll < 82) begin
          dt = span + $urandom_range(0, 2);
        end else if (roll < 95) begin
          dt = $urandom_range(0, span);
        end else begin
          dt = $urandom;
        end
        t = t + dt;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 15) begin
          op = OP_W'($urandom_range(0, 7));
        end else begin
          case (phase_hint)
            PHASE_SETUP: op = (roll < 50) ? OP_SETUP_LINE : OP_PROMPT;
            PHASE_INIT: op = (roll < 75) ? OP_PROMPT : OP_NONE;
            PHASE_REPORT: op = (roll < 40) ? OP_REPORT_OK : (roll < 55) ? OP_REPORT_BAD : OP_NONE;
            PHASE_UNITS: op = (roll < 40) ? OP_UNITS_OK : (roll < 55) ? OP_UNITS_BAD : OP_NONE;
            PHASE_WATCH: op = (roll < 50) ? OP_OTHER : OP_NONE;
            default: op = OP_NONE;
          endcase
        end
        send_poll(t, op);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("summary: %0d polls sent, %0d results checked, %0d commands, %0d link restarts",
             poll_count, checked_count, command_count, restart_count);
    $display("summary: directed bring-up, then random polls under %0d register sets and %s",
             REG_SETS, "four idle patterns");
    if (fail_count == 0 && open_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
